// ===== hw/rtl/zone_passage_detector_defines.svh =====
// Assertion macros for the zone passage detector.
`ifndef ZONE_PASSAGE_DETECTOR_DEFINES_SVH
`define ZONE_PASSAGE_DETECTOR_DEFINES_SVH

// Checked on every rising edge outside reset.
`define ZPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ZPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/zpd_pkg.sv =====
`default_nettype none

package zpd_pkg;

  localparam logic [20:0] NEAR_MARGIN     = 21'd1000;
  localparam logic [19:0] LINE_NEAR_LIMIT = 20'd2000;

  typedef enum logic [1:0] {
    P_OUTSIDE = 2'd0,
    P_NEAR    = 2'd1,
    P_TOUCHED = 2'd2,
    P_PASSED  = 2'd3
  } passage_e;

  typedef enum logic [1:0] {
    SHAPE_LINE    = 2'd0,
    SHAPE_CIRCLE  = 2'd1,
    SHAPE_KEYHOLE = 2'd2,
    SHAPE_SECTOR  = 2'd3
  } shape_e;

  typedef enum logic {
    SCHEME_TOUCH   = 1'b0,
    SCHEME_CLOSEST = 1'b1
  } scheme_e;

  typedef enum logic [2:0] {
    REG_ZONE_SHAPE    = 3'd0,
    REG_SWITCH_SCHEME = 3'd1,
    REG_CIRCLE_RADIUS = 3'd2,
    REG_LINE_LENGTH   = 3'd3,
    REG_INNER_RADIUS  = 3'd4,
    REG_OUTER_RADIUS  = 3'd5,
    REG_MIN_ANGLE     = 3'd6,
    REG_MAX_ANGLE     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    shape_e      zone_shape;
    scheme_e     switch_scheme;
    logic [19:0] circle_radius;
    logic [19:0] line_length;
    logic [19:0] inner_radius;
    logic [19:0] outer_radius;
    logic [15:0] min_angle;
    logic [15:0] max_angle;
  } cfg_t;

  typedef struct packed {
    passage_e    passage;
    logic        prior_valid;
    logic [19:0] prior_range;
  } held_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zpd_classify.sv =====
`default_nettype none

module zpd_classify (
  input  zpd_pkg::cfg_t     cfg_i,
  input  zpd_pkg::held_t    held_i,
  input  logic [19:0]       range_i,
  input  logic [15:0]       bearing_i,
  input  logic              crossed_i,
  output zpd_pkg::passage_e passage_o,
  output zpd_pkg::held_t    held_o
);

  logic              below_held;
  logic              above_held;
  logic              was_touched;
  logic              in_sector;
  logic              inner_set;
  logic [20:0]       range_ext;
  logic [20:0]       circle_near;
  logic [20:0]       outer_near;
  zpd_pkg::passage_e st;
  logic              keep;
  logic              line_mode;
  logic              use_tail;
  logic              is_keyhole;

  assign below_held  = held_i.prior_valid && (range_i < held_i.prior_range);
  assign above_held  = !held_i.prior_valid || (range_i > held_i.prior_range);
  assign was_touched = (held_i.passage == zpd_pkg::P_TOUCHED);
  assign inner_set   = (cfg_i.inner_radius != 20'd0);
  assign range_ext   = {1'b0, range_i};
  assign circle_near = {1'b0, cfg_i.circle_radius} + zpd_pkg::NEAR_MARGIN;
  assign outer_near  = {1'b0, cfg_i.outer_radius} + zpd_pkg::NEAR_MARGIN;
  assign is_keyhole  = (cfg_i.zone_shape == zpd_pkg::SHAPE_KEYHOLE);

  assign in_sector =
    ((cfg_i.min_angle > cfg_i.max_angle) &&
     ((bearing_i > cfg_i.min_angle) || (bearing_i < cfg_i.max_angle))) ||
    ((bearing_i > cfg_i.min_angle) && (bearing_i < cfg_i.max_angle));

  always_comb begin
    st        = zpd_pkg::P_OUTSIDE;
    keep      = 1'b0;
    line_mode = 1'b0;
    use_tail  = 1'b0;
    case (cfg_i.zone_shape)
      zpd_pkg::SHAPE_LINE: begin
        line_mode = 1'b1;
        if (was_touched) begin
          st = zpd_pkg::P_PASSED;
        end else if (range_i < cfg_i.line_length) begin
          if (crossed_i) begin
            st = zpd_pkg::P_TOUCHED;
          end else begin
            st = zpd_pkg::P_NEAR;
          end
        end else if (range_i <= zpd_pkg::LINE_NEAR_LIMIT) begin
          st = zpd_pkg::P_NEAR;
        end
      end
      zpd_pkg::SHAPE_CIRCLE: begin
        if (was_touched) begin
          if (cfg_i.switch_scheme == zpd_pkg::SCHEME_CLOSEST && below_held) begin
            st   = zpd_pkg::P_TOUCHED;
            keep = 1'b1;
          end else begin
            st = zpd_pkg::P_PASSED;
          end
        end else if (range_i < cfg_i.circle_radius) begin
          st   = zpd_pkg::P_TOUCHED;
          keep = 1'b1;
        end else if (range_ext < circle_near) begin
          st   = zpd_pkg::P_NEAR;
          keep = 1'b1;
        end
      end
      zpd_pkg::SHAPE_KEYHOLE, zpd_pkg::SHAPE_SECTOR: begin
        if (was_touched) begin
          if (cfg_i.switch_scheme == zpd_pkg::SCHEME_TOUCH) begin
            st = zpd_pkg::P_PASSED;
          end else if (is_keyhole) begin
            if (inner_set && range_i <= cfg_i.inner_radius && below_held) begin
              st   = zpd_pkg::P_TOUCHED;
              keep = 1'b1;
            end else if (above_held) begin
              st = zpd_pkg::P_PASSED;
            end else begin
              use_tail = 1'b1;
            end
          end else begin
            if (above_held || (inner_set && range_i < cfg_i.inner_radius)) begin
              st = zpd_pkg::P_PASSED;
            end else begin
              use_tail = 1'b1;
            end
          end
        end else if (range_ext > outer_near) begin
          st = zpd_pkg::P_OUTSIDE;
        end else if (range_i > cfg_i.outer_radius) begin
          st   = zpd_pkg::P_NEAR;
          keep = 1'b1;
        end else if (inner_set && range_i < cfg_i.inner_radius) begin
          keep = 1'b1;
          if (is_keyhole) begin
            st = zpd_pkg::P_TOUCHED;
          end else begin
            st = zpd_pkg::P_NEAR;
          end
        end else begin
          use_tail = 1'b1;
        end
      end
      default: begin
        st = zpd_pkg::P_OUTSIDE;
      end
    endcase

    if (use_tail) begin
      if (in_sector) begin
        st   = zpd_pkg::P_TOUCHED;
        keep = 1'b1;
      end else if (was_touched) begin
        st = zpd_pkg::P_PASSED;
      end else begin
        st = zpd_pkg::P_OUTSIDE;
      end
    end
  end

  assign passage_o = st;

  always_comb begin
    held_o.passage = (st == zpd_pkg::P_PASSED) ? zpd_pkg::P_OUTSIDE : st;
    if (line_mode) begin
      held_o.prior_valid = held_i.prior_valid;
      held_o.prior_range = held_i.prior_range;
    end else begin
      held_o.prior_valid = keep;
      held_o.prior_range = keep ? range_i : 20'd0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/zone_passage_detector.sv =====
// Zone passage detector: classifies each position fix against one waypoint zone.
// Input channel (in_valid_i/in_ready_o) carries one fix per word: distance to
// the waypoint, bearing from it and the external line-crossed flag.
// Output channel (out_valid_o/out_ready_i) carries one passage word per fix:
// outside, near, touched or passed, in fix order.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes one register per
// word by index; it is always ready. The user must write it only while no fix
// is in flight; the block itself does not enforce this.
// A fix accepted into the input register is classified from it, and its result
// is loaded into the output register once that register is empty or being
// drained, so a stalled receiver can hold the result back.
// Throughput: one fix per cycle while the receiver is not stalling; the held
// passage state and distance update in the same cycle the result register loads.
// Reset clears both registers' valid flags, the held state (outside, no
// distance held) and loads the default zone: circle of 500 m, first-touch.
// A stalled receiver holds the output word; the input register still takes
// one more fix, then the input channel stalls until the output drains.
`default_nettype none

module zone_passage_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [19:0] range_to_point_i,
  input  logic [15:0] bearing_from_point_i,
  input  logic        line_crossed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  passage_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  `include "zone_passage_detector_defines.svh"

  zpd_pkg::cfg_t     cfg_q, cfg_d;
  zpd_pkg::held_t    held_q, held_d;
  zpd_pkg::held_t    held_next;
  zpd_pkg::passage_e result;
  zpd_pkg::passage_e passage_q;

  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic [19:0] range_q;
  logic [15:0] bearing_q;
  logic        crossed_q;
  logic        in_fire;
  logic        advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_fire     = in_valid_i && in_ready_o;

  zpd_classify u_classify (
    .cfg_i     (cfg_q),
    .held_i    (held_q),
    .range_i   (range_q),
    .bearing_i (bearing_q),
    .crossed_i (crossed_q),
    .passage_o (result),
    .held_o    (held_next)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (zpd_pkg::reg_idx_e'(cfg_index_i))
        zpd_pkg::REG_ZONE_SHAPE:    cfg_d.zone_shape    = zpd_pkg::shape_e'(cfg_data_i[1:0]);
        zpd_pkg::REG_SWITCH_SCHEME: cfg_d.switch_scheme = zpd_pkg::scheme_e'(cfg_data_i[0]);
        zpd_pkg::REG_CIRCLE_RADIUS: cfg_d.circle_radius = cfg_data_i;
        zpd_pkg::REG_LINE_LENGTH:   cfg_d.line_length   = cfg_data_i;
        zpd_pkg::REG_INNER_RADIUS:  cfg_d.inner_radius  = cfg_data_i;
        zpd_pkg::REG_OUTER_RADIUS:  cfg_d.outer_radius  = cfg_data_i;
        zpd_pkg::REG_MIN_ANGLE:     cfg_d.min_angle     = cfg_data_i[15:0];
        zpd_pkg::REG_MAX_ANGLE:     cfg_d.max_angle     = cfg_data_i[15:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    held_d = advance ? held_next : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zone_shape    <= zpd_pkg::SHAPE_CIRCLE;
      cfg_q.switch_scheme <= zpd_pkg::SCHEME_TOUCH;
      cfg_q.circle_radius <= 20'd500;
      cfg_q.line_length   <= 20'd1000;
      cfg_q.inner_radius  <= 20'd0;
      cfg_q.outer_radius  <= 20'd3000;
      cfg_q.min_angle     <= 16'd0;
      cfg_q.max_angle     <= 16'd16384;
      held_q.passage      <= zpd_pkg::P_OUTSIDE;
      held_q.prior_valid  <= 1'b0;
      held_q.prior_range  <= 20'd0;
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      held_q      <= held_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      range_q   <= range_to_point_i;
      bearing_q <= bearing_from_point_i;
      crossed_q <= line_crossed_i;
    end
    if (advance) begin
      passage_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign passage_o   = passage_q;

  `ZPD_ASSERT(a_held_never_passed, held_q.passage != zpd_pkg::P_PASSED, "held passed")
  `ZPD_ASSERT(a_held_range_cleared, !held_q.prior_valid |-> held_q.prior_range == 20'd0, "stale range")
  `ZPD_ASSERT(a_fix_enters, in_fire |=> in_valid_q, "accepted fix lost")
  `ZPD_ASSERT(a_result_loads, advance |=> out_valid_q, "result not offered")
  `ZPD_ASSERT(a_passed_resets, advance && result == zpd_pkg::P_PASSED |=> held_q.passage == zpd_pkg::P_OUTSIDE, "no reset after passed")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 16;
  localparam int FIXES_PER_PHASE = 40;

  class passage_board;
    zpd_pkg::shape_e   shape;
    zpd_pkg::scheme_e  scheme;
    logic [19:0]       circle_radius;
    logic [19:0]       line_length;
    logic [19:0]       inner_radius;
    logic [19:0]       outer_radius;
    logic [15:0]       min_angle;
    logic [15:0]       max_angle;
    zpd_pkg::passage_e held_passage;
    logic [19:0]       held_range;
    bit                held_valid;
    zpd_pkg::passage_e passage_q[$];
    int                errors;

    function new();
      shape         = zpd_pkg::SHAPE_CIRCLE;
      scheme        = zpd_pkg::SCHEME_TOUCH;
      circle_radius = 20'd500;
      line_length   = 20'd1000;
      inner_radius  = '0;
      outer_radius  = 20'd3000;
      min_angle     = '0;
      max_angle     = 16'd16384;
      held_passage  = zpd_pkg::P_OUTSIDE;
      held_range    = '0;
      held_valid    = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(zpd_pkg::reg_idx_e idx, logic [19:0] data);
      case (idx)
        zpd_pkg::REG_ZONE_SHAPE:    shape = zpd_pkg::shape_e'(data[1:0]);
        zpd_pkg::REG_SWITCH_SCHEME: scheme = zpd_pkg::scheme_e'(data[0]);
        zpd_pkg::REG_CIRCLE_RADIUS: circle_radius = data;
        zpd_pkg::REG_LINE_LENGTH:   line_length = data;
        zpd_pkg::REG_INNER_RADIUS:  inner_radius = data;
        zpd_pkg::REG_OUTER_RADIUS:  outer_radius = data;
        zpd_pkg::REG_MIN_ANGLE:     min_angle = data[15:0];
        zpd_pkg::REG_MAX_ANGLE:     max_angle = data[15:0];
        default: ;
      endcase
    endfunction

    function bit closer(logic [19:0] r);
      return held_valid && r < held_range;
    endfunction

    function bit farther(logic [19:0] r);
      return !held_valid || r > held_range;
    endfunction

    function zpd_pkg::passage_e settle(zpd_pkg::passage_e st, bit keep, logic [19:0] r);
      held_passage = (st == zpd_pkg::P_PASSED) ? zpd_pkg::P_OUTSIDE : st;
      held_valid   = keep;
      held_range   = keep ? r : '0;
      return st;
    endfunction

    function zpd_pkg::passage_e line_step(logic [19:0] r, logic crossed);
      if (held_passage == zpd_pkg::P_TOUCHED) begin
        held_passage = zpd_pkg::P_OUTSIDE;
        return zpd_pkg::P_PASSED;
      end
      if (r < line_length) begin
        held_passage = crossed ? zpd_pkg::P_TOUCHED : zpd_pkg::P_NEAR;
        return held_passage;
      end
      held_passage = (r <= zpd_pkg::LINE_NEAR_LIMIT) ? zpd_pkg::P_NEAR : zpd_pkg::P_OUTSIDE;
      return held_passage;
    endfunction

    function zpd_pkg::passage_e circle_step(logic [19:0] r);
      if (held_passage == zpd_pkg::P_TOUCHED) begin
        if (scheme == zpd_pkg::SCHEME_CLOSEST && closer(r))
          return settle(zpd_pkg::P_TOUCHED, 1'b1, r);
        return settle(zpd_pkg::P_PASSED, 1'b0, '0);
      end
      if (r < circle_radius) return settle(zpd_pkg::P_TOUCHED, 1'b1, r);
      if (21'(r) < 21'(circle_radius) + zpd_pkg::NEAR_MARGIN)
        return settle(zpd_pkg::P_NEAR, 1'b1, r);
      return settle(zpd_pkg::P_OUTSIDE, 1'b0, '0);
    endfunction

    function bit in_sector(logic [15:0] b);
      if (min_angle > max_angle && (b > min_angle || b < max_angle)) return 1'b1;
      return b > min_angle && b < max_angle;
    endfunction

    function zpd_pkg::passage_e sector_step(logic [19:0] r, logic [15:0] b, bit keyhole);
      if (held_passage == zpd_pkg::P_TOUCHED) begin
        if (scheme == zpd_pkg::SCHEME_TOUCH) return settle(zpd_pkg::P_PASSED, 1'b0, '0);
        if (keyhole) begin
          if (inner_radius != 0 && r <= inner_radius && closer(r))
            return settle(zpd_pkg::P_TOUCHED, 1'b1, r);
          if (farther(r)) return settle(zpd_pkg::P_PASSED, 1'b0, '0);
        end else begin
          if (farther(r)) return settle(zpd_pkg::P_PASSED, 1'b0, '0);
          if (inner_radius != 0 && r < inner_radius)
            return settle(zpd_pkg::P_PASSED, 1'b0, '0);
        end
      end else begin
        if (21'(r) > 21'(outer_radius) + zpd_pkg::NEAR_MARGIN)
          return settle(zpd_pkg::P_OUTSIDE, 1'b0, '0);
        if (r > outer_radius) return settle(zpd_pkg::P_NEAR, 1'b1, r);
        if (keyhole) begin
          if (inner_radius != 0 && r < inner_radius)
            return settle(zpd_pkg::P_TOUCHED, 1'b1, r);
        end else begin
          if ((inner_radius != 0 || inner_radius == outer_radius) && r < inner_radius)
            return settle(zpd_pkg::P_NEAR, 1'b1, r);
        end
      end
      if (in_sector(b)) return settle(zpd_pkg::P_TOUCHED, 1'b1, r);
      if (held_passage == zpd_pkg::P_TOUCHED) return settle(zpd_pkg::P_PASSED, 1'b0, '0);
      return settle(zpd_pkg::P_OUTSIDE, 1'b0, '0);
    endfunction

    function void note_fix(logic [19:0] r, logic [15:0] b, logic crossed);
      zpd_pkg::passage_e st;
      case (shape)
        zpd_pkg::SHAPE_LINE:    st = line_step(r, crossed);
        zpd_pkg::SHAPE_CIRCLE:  st = circle_step(r);
        zpd_pkg::SHAPE_KEYHOLE: st = sector_step(r, b, 1'b1);
        default:                st = sector_step(r, b, 1'b0);
      endcase
      passage_q.push_back(st);
    endfunction

    function void check_passage(logic [1:0] actual);
      zpd_pkg::passage_e want;
      if (passage_q.size() == 0) begin
        errors++;
        $error("passage: expected none, actual %0d", actual);
        return;
      end
      want = passage_q.pop_front();
      if (actual !== want) begin
        errors++;
        $error("passage: expected %0d, actual %0d", want, actual);
      end
    endfunction

    function int pending();
      return passage_q.size();
    endfunction
  endclass

  logic        clk_i                = 1'b0;
  logic        rst_ni               = 1'b0;
  logic        in_valid_i           = 1'b0;
  logic        in_ready_o;
  logic [19:0] range_to_point_i     = '0;
  logic [15:0] bearing_from_point_i = '0;
  logic        line_crossed_i       = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i          = 1'b0;
  logic [1:0]  passage_o;
  logic        cfg_valid_i          = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i          = '0;
  logic [19:0] cfg_data_i           = '0;

  passage_board board;
  bit           bursty = 1'b1;
  int           cycles = 0;

  zone_passage_detector u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && board != null) begin
      if (out_valid_o === 1'b1 && out_ready_i) board.check_passage(passage_o);
      if (in_valid_i && in_ready_o === 1'b1)
        board.note_fix(range_to_point_i, bearing_from_point_i, line_crossed_i);
    end
  end

  // stall the receiver for a random number of cycles per word
  initial begin
    int stall;
    forever begin
      stall = bursty ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  task automatic send_fix(logic [19:0] r, logic [15:0] b, logic crossed);
    int gap;
    gap = bursty ? $urandom_range(0, 17) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    range_to_point_i     <= r;
    bearing_from_point_i <= b;
    line_crossed_i       <= crossed;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic write_reg_word(zpd_pkg::reg_idx_e idx, logic [19:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold the sender until every passage word is back
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [19:0] pick_radius(int mode);
    if (mode == 0) return 20'hFFFFF;
    if (mode == 1) return '0;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 20'hFFFFF;
      default: return 20'($urandom_range(1, 6000));
    endcase
  endfunction

  function automatic logic [15:0] pick_angle(int mode);
    if (mode == 0) return 16'hFFFF;
    if (mode == 1) return '0;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic set_zone(int p);
    int          mode;
    logic [19:0] outer;
    logic [19:0] inner;
    mode  = p % 5;
    outer = pick_radius(mode);
    inner = (mode > 1 && $urandom_range(0, 5) == 0) ? outer : pick_radius(mode);
    write_reg_word(zpd_pkg::REG_ZONE_SHAPE, {18'($urandom), 2'(p % 4)});
    write_reg_word(zpd_pkg::REG_SWITCH_SCHEME, {19'($urandom), 1'((p / 4) % 2)});
    write_reg_word(zpd_pkg::REG_CIRCLE_RADIUS, pick_radius(mode));
    write_reg_word(zpd_pkg::REG_LINE_LENGTH, pick_radius(mode));
    write_reg_word(zpd_pkg::REG_OUTER_RADIUS, outer);
    write_reg_word(zpd_pkg::REG_INNER_RADIUS, inner);
    write_reg_word(zpd_pkg::REG_MIN_ANGLE, {4'($urandom), pick_angle(mode)});
    write_reg_word(zpd_pkg::REG_MAX_ANGLE, {4'($urandom), pick_angle(mode)});
  endtask

  function automatic logic [15:0] pick_bearing();
    case ($urandom_range(0, 7))
      0:       return board.min_angle;
      1:       return board.max_angle;
      2:       return board.min_angle + 16'd1;
      3:       return board.max_angle - 16'd1;
      4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] noise_range();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  // fly approach and departure legs through the zone, with stray fixes mixed in
  task automatic run_track(int count);
    longint      cur;
    longint      lo;
    longint      hi;
    longint      step;
    int          scale;
    bit          rising;
    logic [19:0] r;
    case (board.shape)
      zpd_pkg::SHAPE_LINE:   scale = board.line_length + 2000;
      zpd_pkg::SHAPE_CIRCLE: scale = board.circle_radius;
      default:               scale = board.outer_radius;
    endcase
    hi = 2 * longint'(scale) + 2500;
    if (hi > 64'hFFFFF) hi = 64'hFFFFF;
    cur    = hi;
    rising = 1'b0;
    lo     = $urandom_range(0, scale);
    step   = $urandom_range(1, scale / 6 + 60);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = noise_range();
      end else begin
        if (rising) cur = cur + step;
        else cur = (cur > step) ? cur - step : 0;
        if (cur >= hi) begin
          cur    = hi;
          rising = 1'b0;
          step   = $urandom_range(1, scale / 6 + 60);
        end else if (cur <= lo) begin
          rising = 1'b1;
          lo     = $urandom_range(0, scale);
          step   = $urandom_range(1, scale / 6 + 60);
        end
        r = cur[19:0];
      end
      if ($urandom_range(0, 49) == 0) drain_block();
      send_fix(r, pick_bearing(), $urandom_range(0, 2) == 0);
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_fix(20'd0, 16'h0000, 1'b0);
    send_fix(20'hFFFFF, 16'hFFFF, 1'b1);
    send_fix(20'd499, 16'h8000, 1'b0);
    send_fix(20'd499, 16'h8000, 1'b0);
    send_fix(20'd1499, 16'h1234, 1'b1);
    send_fix(20'd1500, 16'h1234, 1'b0);

    drain_block();
    write_reg_word(zpd_pkg::REG_SWITCH_SCHEME, 20'(zpd_pkg::SCHEME_CLOSEST));
    send_fix(20'd400, 16'h0000, 1'b0);
    send_fix(20'd300, 16'h0000, 1'b0);
    send_fix(20'd300, 16'h0000, 1'b0);
    send_fix(20'd500, 16'h0000, 1'b0);

    drain_block();
    write_reg_word(zpd_pkg::REG_ZONE_SHAPE, 20'(zpd_pkg::SHAPE_LINE));
    send_fix(20'd999, 16'h0000, 1'b1);
    send_fix(20'd5000, 16'h0000, 1'b0);
    send_fix(20'd1000, 16'h0000, 1'b1);
    send_fix(20'd2000, 16'h0000, 1'b0);
    send_fix(20'd2001, 16'h0000, 1'b1);
    send_fix(20'd10, 16'h0000, 1'b0);

    // sector wrapping through north
    drain_block();
    write_reg_word(zpd_pkg::REG_ZONE_SHAPE, 20'(zpd_pkg::SHAPE_SECTOR));
    write_reg_word(zpd_pkg::REG_MIN_ANGLE, 20'd60000);
    write_reg_word(zpd_pkg::REG_MAX_ANGLE, 20'd5000);
    send_fix(20'd100, 16'd60000, 1'b0);
    send_fix(20'd100, 16'd0, 1'b0);
    send_fix(20'd50, 16'hFFFF, 1'b0);
    send_fix(20'd200, 16'd5000, 1'b0);

    // keyhole, closest approach, range level with the held one
    drain_block();
    write_reg_word(zpd_pkg::REG_ZONE_SHAPE, 20'(zpd_pkg::SHAPE_KEYHOLE));
    write_reg_word(zpd_pkg::REG_INNER_RADIUS, 20'd500);
    send_fix(20'd400, 16'd1000, 1'b0);
    send_fix(20'd400, 16'd30000, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain_block();
      bursty = (p % 3 != 0);
      set_zone(p);
      run_track(FIXES_PER_PHASE);
    end

    drain_block();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
